@@ rtl/tdpc_pkg.sv @@
// Shared types and constants for the truncated displacement pair cost block.
// Depends on nothing; every other file of the block imports it.
package tdpc_pkg;

    // Default parameter values handed to the top level.
    localparam int COORD_BITS_DEF = 9;
    localparam int FRAC_BITS_DEF  = 4;

    // Fixed field and register widths.
    localparam int REG_BITS   = 10;
    localparam int COST_BITS  = 14;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    // The length is scaled by ten, so its square is scaled by a hundred.
    localparam int LEN_SCALE_SQ = 100;
    localparam int SCALE_BITS   = 7;

    // Register reset values.
    localparam logic [REG_BITS-1:0] DUMMY_RESET = REG_BITS'(75);
    localparam logic [REG_BITS-1:0] TRUNC_RESET = REG_BITS'(300);

    // Register indexes on the configuration port.
    typedef enum logic [0:0] {
        REG_DUMMY_COST = 1'b0,
        REG_TRUNC_COST = 1'b1
    } tdpc_reg_idx_t;

    // Configuration handed from the register file to the datapath.
    typedef struct packed {
        logic [REG_BITS-1:0]   dummy_cost;
        logic [REG_BITS-1:0]   trunc_cost;
        logic [2*REG_BITS-1:0] trunc_sq;
    } tdpc_cfg_t;

    // Decision flags that travel with each transaction through the pipeline.
    typedef struct packed {
        logic dummy;
        logic inf;
        logic sat;
    } tdpc_tag_t;

endpackage

@@ rtl/truncated_displacement_pair_cost.sv @@
// Truncated displacement pair cost: one entry of a pairwise cost matrix per transaction.
// Depends on tdpc_pkg, tdpc_regs, tdpc_front and tdpc_sqrt.
//
// Each input transaction carries two anchor points, one candidate point per anchor and
// two dummy-label flags, and produces exactly one result transaction. The cost is ten
// times the length of the displacement difference, in fixed point with FRAC_BITS
// fraction bits, truncated and clamped at trunc_cost; a dummy label gives dummy_cost,
// and otherwise a candidate with x equal to minus one gives the infinite flag with a
// zero cost. The block accepts one transaction every clock cycle while in_stall is low.
// With the default four fraction bits there are nineteen register stages in all, the
// first loaded at the accepting edge: four front-end stages form the squared, scaled
// length and test it against the squared ceiling, then the square-root pipeline settles
// one root bit per stage, and an output register presents the result. A two-entry
// output buffer lets a transaction be accepted while a result waits to be taken;
// in_stall rises only once both entries are occupied. Register writes take effect at
// the saturation compare and the output select, not at acceptance, and must be made
// while no transaction is in flight.
module truncated_displacement_pair_cost
    import tdpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_BITS-1:0]       paddr,
    input  logic [DATA_BITS-1:0]       pwdata,
    output logic [DATA_BITS-1:0]       prdata,
    output logic                       pready,
    // Input channel.
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [COORD_BITS-1:0]      anchor1_x,
    input  logic [COORD_BITS-1:0]      anchor1_y,
    input  logic [COORD_BITS-1:0]      anchor2_x,
    input  logic [COORD_BITS-1:0]      anchor2_y,
    input  logic signed [COORD_BITS:0] cand1_x,
    input  logic signed [COORD_BITS:0] cand1_y,
    input  logic signed [COORD_BITS:0] cand2_x,
    input  logic signed [COORD_BITS:0] cand2_y,
    input  logic                       first_is_dummy,
    input  logic                       second_is_dummy,
    // Output channel.
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [COST_BITS-1:0]       cost_scaled,
    output logic                       cost_infinite
);

    localparam int ROOT_BITS = REG_BITS + FRAC_BITS;
    localparam int SELW      = (ROOT_BITS > COST_BITS) ? ROOT_BITS : COST_BITS;

    tdpc_cfg_t              cfg;
    logic                   advance;
    logic                   in_take;
    logic                   n_valid;
    logic [2*ROOT_BITS-1:0] n_value;
    tdpc_tag_t              n_tag;
    logic                   r_valid;
    logic [ROOT_BITS-1:0]   r_root;
    tdpc_tag_t              r_tag;

    logic [SELW-1:0]        sel_wide;
    logic [COST_BITS-1:0]   res_cost;
    logic                   res_inf;

    logic                   o_valid_reg;
    logic [COST_BITS-1:0]   o_cost_reg;
    logic                   o_inf_reg;
    logic                   skid_valid_reg;
    logic [COST_BITS-1:0]   skid_cost_reg;
    logic                   skid_inf_reg;
    logic                   out_take;

    // The whole pipeline moves together unless the output buffer is full.
    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && advance;
    assign out_take = o_valid_reg && !out_stall;

    tdpc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tdpc_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ROOT_BITS  (ROOT_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .in_take         (in_take),
        .anchor1_x       (anchor1_x),
        .anchor1_y       (anchor1_y),
        .anchor2_x       (anchor2_x),
        .anchor2_y       (anchor2_y),
        .cand1_x         (cand1_x),
        .cand1_y         (cand1_y),
        .cand2_x         (cand2_x),
        .cand2_y         (cand2_y),
        .first_is_dummy  (first_is_dummy),
        .second_is_dummy (second_is_dummy),
        .cfg             (cfg),
        .n_valid         (n_valid),
        .n_value         (n_value),
        .n_tag           (n_tag)
    );

    tdpc_sqrt #(
        .ROOT_BITS (ROOT_BITS)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (n_valid),
        .in_value  (n_value),
        .in_tag    (n_tag),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_tag   (r_tag)
    );

    // The dummy label wins over the infinite flag, and both win over the length.
    // When the squared length reaches the squared ceiling the ceiling itself is the
    // answer, which also covers lengths too long for the root pipeline.
    always_comb
    begin
        if (r_tag.dummy)
        begin
            sel_wide = SELW'(cfg.dummy_cost) << FRAC_BITS;
        end
        else if (r_tag.inf)
        begin
            sel_wide = '0;
        end
        else if (r_tag.sat)
        begin
            sel_wide = SELW'(cfg.trunc_cost) << FRAC_BITS;
        end
        else
        begin
            sel_wide = SELW'(r_root);
        end
        res_cost = sel_wide[COST_BITS-1:0];
        res_inf  = !r_tag.dummy && r_tag.inf;
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!o_valid_reg || out_take)
        begin
            o_valid_reg <= r_valid;
        end
        else if (r_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                o_cost_reg <= skid_cost_reg;
                o_inf_reg  <= skid_inf_reg;
            end
        end
        else if (!o_valid_reg || out_take)
        begin
            o_cost_reg <= res_cost;
            o_inf_reg  <= res_inf;
        end
        else
        begin
            skid_cost_reg <= res_cost;
            skid_inf_reg  <= res_inf;
        end
    end

    assign out_valid     = o_valid_reg;
    assign cost_scaled   = o_cost_reg;
    assign cost_infinite = o_inf_reg;

endmodule

@@ rtl/tdpc_regs.sv @@
// Configuration register file behind an APB-style port.
// Depends on tdpc_pkg for widths, reset values and register indexes.
module tdpc_regs
    import tdpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output tdpc_cfg_t            cfg
);

    logic [REG_BITS-1:0]   dummy_reg;
    logic [REG_BITS-1:0]   trunc_reg;
    logic [2*REG_BITS-1:0] trunc_sq_reg;
    logic                  wr_en;
    tdpc_reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = tdpc_reg_idx_t'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dummy_reg <= DUMMY_RESET;
            trunc_reg <= TRUNC_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DUMMY_COST: dummy_reg <= pwdata[REG_BITS-1:0];
                REG_TRUNC_COST: trunc_reg <= pwdata[REG_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // The square of the ceiling is kept ready for the saturation compare.
    always_ff @(posedge clk)
    begin
        trunc_sq_reg <= (2*REG_BITS)'(trunc_reg) * (2*REG_BITS)'(trunc_reg);
    end

    always_comb
    begin
        unique case (idx)
            REG_DUMMY_COST: prdata = DATA_BITS'(dummy_reg);
            REG_TRUNC_COST: prdata = DATA_BITS'(trunc_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.dummy_cost = dummy_reg;
    assign cfg.trunc_cost = trunc_reg;
    assign cfg.trunc_sq   = trunc_sq_reg;

endmodule

@@ rtl/tdpc_front.sv @@
// Front end: displacement difference, squares, scaling and saturation test.
// Depends on tdpc_pkg for the tag and configuration structs.
module tdpc_front
    import tdpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ROOT_BITS  = REG_BITS + FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_take,
    input  logic [COORD_BITS-1:0]         anchor1_x,
    input  logic [COORD_BITS-1:0]         anchor1_y,
    input  logic [COORD_BITS-1:0]         anchor2_x,
    input  logic [COORD_BITS-1:0]         anchor2_y,
    input  logic signed [COORD_BITS:0]    cand1_x,
    input  logic signed [COORD_BITS:0]    cand1_y,
    input  logic signed [COORD_BITS:0]    cand2_x,
    input  logic signed [COORD_BITS:0]    cand2_y,
    input  logic                          first_is_dummy,
    input  logic                          second_is_dummy,
    input  tdpc_cfg_t                     cfg,
    output logic                          n_valid,
    output logic [2*ROOT_BITS-1:0]        n_value,
    output tdpc_tag_t                     n_tag
);

    localparam int DW   = COORD_BITS + 3;
    localparam int AW   = COORD_BITS + 2;
    localparam int SQW  = 2 * AW;
    localparam int SUMW = SQW + 1;
    localparam int MW   = SUMW + SCALE_BITS;
    localparam int NW   = MW + 2 * FRAC_BITS;
    localparam int CMPW = (NW > 2 * ROOT_BITS) ? NW : 2 * ROOT_BITS;

    // Stage A: differences.
    logic signed [DW-1:0] dx_next, dy_next;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic                 va_reg;
    tdpc_tag_t            tag_a_next, tag_a_reg;

    // Stage B: squares.
    logic [DW-1:0]  ax_full, ay_full;
    logic [AW-1:0]  ax, ay;
    logic [SQW-1:0] sqx_reg, sqy_reg;
    logic           vb_reg;
    tdpc_tag_t      tag_b_reg;

    // Stage C: scaled sum.
    logic [SUMW-1:0] sum;
    logic [MW-1:0]   m_reg;
    logic            vc_reg;
    tdpc_tag_t       tag_c_reg;

    // Stage D: shift into fixed point and compare against the squared ceiling.
    logic [CMPW-1:0]         n_ext, ceil_sq;
    logic [2*ROOT_BITS-1:0]  n_reg;
    logic                    vd_reg;
    tdpc_tag_t               tag_d_next;
    tdpc_tag_t               tag_d_reg;

    always_comb
    begin
        dx_next = DW'(cand2_x) - DW'(signed'({1'b0, anchor2_x}))
                - DW'(cand1_x) + DW'(signed'({1'b0, anchor1_x}));
        dy_next = DW'(cand2_y) - DW'(signed'({1'b0, anchor2_y}))
                - DW'(cand1_y) + DW'(signed'({1'b0, anchor1_y}));
        tag_a_next.dummy = first_is_dummy || second_is_dummy;
        tag_a_next.inf   = (cand1_x == '1) || (cand2_x == '1);
        tag_a_next.sat   = 1'b0;
    end

    assign ax_full = dx_reg[DW-1] ? DW'(-dx_reg) : dx_reg;
    assign ay_full = dy_reg[DW-1] ? DW'(-dy_reg) : dy_reg;
    assign ax      = ax_full[AW-1:0];
    assign ay      = ay_full[AW-1:0];

    assign sum     = SUMW'(sqx_reg) + SUMW'(sqy_reg);
    assign n_ext   = CMPW'(m_reg) << (2 * FRAC_BITS);
    assign ceil_sq = CMPW'(cfg.trunc_sq) << (2 * FRAC_BITS);

    always_comb
    begin
        tag_d_next     = tag_c_reg;
        tag_d_next.sat = n_ext >= ceil_sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= in_take;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            tag_a_reg     <= tag_a_next;
            sqx_reg       <= SQW'(ax) * SQW'(ax);
            sqy_reg       <= SQW'(ay) * SQW'(ay);
            tag_b_reg     <= tag_a_reg;
            m_reg         <= MW'(sum) * MW'(LEN_SCALE_SQ);
            tag_c_reg     <= tag_b_reg;
            n_reg         <= n_ext[2*ROOT_BITS-1:0];
            tag_d_reg     <= tag_d_next;
        end
    end

    assign n_valid = vd_reg;
    assign n_value = n_reg;
    assign n_tag   = tag_d_reg;

endmodule

@@ rtl/tdpc_sqrt.sv @@
// Pipelined integer square root, one root bit settled per register stage.
// Depends on tdpc_pkg for the tag struct carried alongside the operand.
module tdpc_sqrt
    import tdpc_pkg::*;
#(
    parameter int ROOT_BITS = REG_BITS + FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic [2*ROOT_BITS-1:0] in_value,
    input  tdpc_tag_t              in_tag,
    output logic                   out_valid,
    output logic [ROOT_BITS-1:0]   out_root,
    output tdpc_tag_t              out_tag
);

    localparam int RMW = 2 * ROOT_BITS;

    logic [RMW-1:0]       rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];
    tdpc_tag_t            tag_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] valid_reg;

    for (genvar g = 0; g < ROOT_BITS; g++)
    begin : g_bit
        localparam int BIT = ROOT_BITS - 1 - g;

        logic [RMW-1:0]       rem_in;
        logic [ROOT_BITS-1:0] root_in;
        tdpc_tag_t            tag_in;
        logic                 valid_in;
        logic [RMW-1:0]       trial;
        logic                 fits;

        if (g == 0)
        begin : g_head
            assign rem_in   = in_value;
            assign root_in  = '0;
            assign tag_in   = in_tag;
            assign valid_in = in_valid;
        end
        else
        begin : g_body
            assign rem_in   = rem_reg[g-1];
            assign root_in  = root_reg[g-1];
            assign tag_in   = tag_reg[g-1];
            assign valid_in = valid_reg[g-1];
        end

        // Adding this bit raises the square by 2*root*2^BIT + 4^BIT.
        assign trial = (RMW'(root_in) << (BIT + 1)) | (RMW'(1) << (2 * BIT));
        assign fits  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[g]  <= fits ? rem_in - trial : rem_in;
                root_reg[g] <= fits ? (root_in | (ROOT_BITS'(1) << BIT)) : root_in;
                tag_reg[g]  <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_BITS-1];
    assign out_root  = root_reg[ROOT_BITS-1];
    assign out_tag   = tag_reg[ROOT_BITS-1];

endmodule

@@ rtl/tdpc_checker.sv @@
// Port-level checks for the truncated displacement pair cost block, bound to the top level.
// Depends on tdpc_pkg for the cost width.
module tdpc_checker
    import tdpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_stall,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [COST_BITS-1:0] cost_scaled,
    input  logic                 cost_infinite
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    // An infinite cost always carries a zero cost field.
    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cost_infinite |-> cost_scaled == '0)
        else $error("infinite cost with non-zero cost field");

    // The input side is held back only while a result is being held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // A full buffer always has a result on offer.
    a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled while no result is offered");

endmodule

bind truncated_displacement_pair_cost tdpc_checker u_tdpc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cost_scaled   (cost_scaled),
    .cost_infinite (cost_infinite)
);
